// ----- src/sls_pkg.sv -----
package sls_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int OFFSET_W = 6;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic scan;
      logic load;
   } sls_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_mem;
      logic scan_done;
      logic out_free;
   } sls_stat_type;

endpackage

// ----- src/sls_req_if.sv -----
interface sls_req_if import sls_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [VALUE_W-1:0]  item_value;

   modport source (output valid, cmd, item_value, input ready);
   modport sink   (input valid, cmd, item_value, output ready);
endinterface

// ----- src/sls_rsp_if.sv -----
interface sls_rsp_if import sls_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic                found;
   logic [OFFSET_W-1:0] offset_from_top;
   logic [FILL_W-1:0]   fill_count;
   logic                is_empty;
   logic [STATUS_W-1:0] status;

   modport source (output valid, read_value, found, offset_from_top, fill_count, is_empty,
                   status, input ready);
   modport sink   (input valid, read_value, found, offset_from_top, fill_count, is_empty,
                   status, output ready);
endinterface

// ----- src/sls_ram.sv -----
module sls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sls_ctrl.sv -----
module sls_ctrl import sls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output sls_cmd_type  ctl,
   input  sls_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = stat.need_mem ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               ctl.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/sls_datapath.sv -----
module sls_datapath import sls_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  sls_cmd_type         ctl,
   output sls_stat_type        stat,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [VALUE_W-1:0]  req_item_value,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_found,
   output logic [OFFSET_W-1:0] rsp_offset_from_top,
   output logic [FILL_W-1:0]   rsp_fill_count,
   output logic                rsp_is_empty,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         dist_ff, dist_in;
   logic [DATA_WIDTH-1:0] res_rd_ff, res_rd_in;
   logic                  res_found_ff, res_found_in;
   logic [AW-1:0]         res_off_ff, res_off_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;

   logic                  out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]    out_value_ff, out_value_in;
   logic                  out_found_ff, out_found_in;
   logic [OFFSET_W-1:0]   out_offset_ff, out_offset_in;
   logic [FILL_W-1:0]     out_fill_ff, out_fill_in;
   logic                  out_empty_ff, out_empty_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;

   logic                  is_empty, is_full, is_pop_peek, match, last;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] rd_data;

   sls_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cnt_ff)),
      .wr_data (val_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign is_empty    = (cnt_ff == '0);
   assign is_full     = (cnt_ff == CW'(DEPTH));
   assign is_pop_peek = (cmd_ff == CMD_POP) || (cmd_ff == CMD_PEEK);
   assign match       = (rd_data == val_ff);
   assign last        = (CW'(dist_ff) == cnt_ff - CW'(1));
   assign wr_en       = ctl.exec && (cmd_ff == CMD_PUSH) && !is_full;

   assign stat.need_mem  = !is_empty && (is_pop_peek || (cmd_ff == CMD_SEARCH));
   assign stat.scan_done = is_pop_peek || match || last;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      dist_in       = dist_ff;
      res_rd_in     = res_rd_ff;
      res_found_in  = res_found_ff;
      res_off_in    = res_off_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_found_in  = out_found_ff;
      out_offset_in = out_offset_ff;
      out_fill_in   = out_fill_ff;
      out_empty_in  = out_empty_ff;
      out_status_in = out_status_ff;

      if (ctl.accept) begin
         cmd_in  = req_cmd;
         val_in  = DATA_WIDTH'(req_item_value);
         addr_in = AW'(cnt_ff - CW'(1));
         dist_in = '0;
      end

      if (ctl.exec) begin
         res_rd_in     = '0;
         res_found_in  = 1'b0;
         res_off_in    = '0;
         res_status_in = STATUS_OK;
         addr_in       = addr_ff - AW'(1);
         case (cmd_ff)
            CMD_PUSH: begin
               if (is_full) begin
                  res_status_in = STATUS_OVERFLOW;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            CMD_POP, CMD_PEEK: begin
               if (is_empty) begin
                  res_status_in = STATUS_UNDERFLOW;
               end
            end
            CMD_CLEAR: begin
               cnt_in = '0;
            end
            default: begin
            end
         endcase
      end

      // rd_data holds the entry dist_ff below the top
      if (ctl.scan) begin
         addr_in = addr_ff - AW'(1);
         dist_in = dist_ff + AW'(1);
         if (is_pop_peek) begin
            res_rd_in = rd_data;
            if (cmd_ff == CMD_POP) begin
               cnt_in = cnt_ff - CW'(1);
            end
         end else if (match) begin
            res_found_in = 1'b1;
            res_off_in   = dist_ff;
         end
      end

      if (ctl.load) begin
         out_valid_in  = 1'b1;
         out_value_in  = VALUE_W'(res_rd_ff);
         out_found_in  = res_found_ff;
         out_offset_in = OFFSET_W'(res_off_ff);
         out_fill_in   = FILL_W'(cnt_ff);
         out_empty_in  = is_empty;
         out_status_in = res_status_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      addr_ff       <= addr_in;
      dist_ff       <= dist_in;
      res_rd_ff     <= res_rd_in;
      res_found_ff  <= res_found_in;
      res_off_ff    <= res_off_in;
      res_status_ff <= res_status_in;
      out_value_ff  <= out_value_in;
      out_found_ff  <= out_found_in;
      out_offset_ff <= out_offset_in;
      out_fill_ff   <= out_fill_in;
      out_empty_ff  <= out_empty_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_value      = out_value_ff;
   assign rsp_found           = out_found_ff;
   assign rsp_offset_from_top = out_offset_ff;
   assign rsp_fill_count      = out_fill_ff;
   assign rsp_is_empty        = out_empty_ff;
   assign rsp_status          = out_status_ff;

endmodule

// ----- src/searchable_lifo_stack.sv -----
// LIFO stack of DEPTH words with push, pop, peek, search and clear; one result per
// command. Commands are taken one at a time: push, clear, undefined commands and pop or
// peek on an empty stack pass from accept through EXEC to DONE, pop and peek also pass
// SCAN to read the top entry, and a search compares k entries in SCAN, where k (0 on an
// empty stack, else 1 to fill level) counts entries compared, top first, by a single
// comparator fed from the stack RAM's one read port. A finished result sits in an output
// register, so the next command is accepted while it waits to be taken.
module searchable_lifo_stack import sls_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   sls_req_if.sink   req_chan,
   sls_rsp_if.source rsp_chan
);

   sls_cmd_type  ctl;
   sls_stat_type stat;

   sls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .ctl       (ctl),
      .stat      (stat)
   );

   sls_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_cmd             (req_chan.cmd),
      .req_item_value      (req_chan.item_value),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_read_value      (rsp_chan.read_value),
      .rsp_found           (rsp_chan.found),
      .rsp_offset_from_top (rsp_chan.offset_from_top),
      .rsp_fill_count      (rsp_chan.fill_count),
      .rsp_is_empty        (rsp_chan.is_empty),
      .rsp_status          (rsp_chan.status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("accepted a second item back to back");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_UNDERFLOW)
         |-> (rsp_chan.is_empty && rsp_chan.read_value == '0))
      else $error("underflow on a non-empty stack");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_OVERFLOW)
         |-> (rsp_chan.fill_count == FILL_W'(DEPTH)))
      else $error("overflow reported below full");

   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.found) |-> (rsp_chan.offset_from_top == '0))
      else $error("nonzero offset without a hit");

endmodule

// ----- sim/searchable_lifo_stack_tb.sv -----
`timescale 1ns / 1ps

module searchable_lifo_stack_tb import sls_pkg::*; ();

   localparam int STACK_DEPTH = 64;
   localparam int IDLE_PCT    = 18;
   localparam int POOL_SIZE   = 8;
   localparam int ITEM_TARGET = 1225;

   // commands the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      bit                 settle;   // hold until all results are back
   } stack_cmd_type;

   typedef struct {
      logic [VALUE_W-1:0]  read_value;
      logic                found;
      logic [OFFSET_W-1:0] offset_from_top;
      logic [FILL_W-1:0]   fill_count;
      logic                is_empty;
      logic [STATUS_W-1:0] status;
   } stack_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sls_req_if req_chan ();
   sls_rsp_if rsp_chan ();

   searchable_lifo_stack #(
      .DEPTH      (STACK_DEPTH),
      .DATA_WIDTH (VALUE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   stack_cmd_type      cmd_backlog[$];
   stack_result_type   stack_results_q[$];
   stack_cmd_type      next_cmd;
   logic [VALUE_W-1:0] shadow_words[STACK_DEPTH];
   int                 shadow_fill = 0;
   logic [VALUE_W-1:0] value_pool[POOL_SIZE];
   bit                 req_busy    = 1'b0;
   int                 items_taken = 0;
   int                 mismatches  = 0;
   logic               calm;

   assign calm = (items_taken >= 400) && (items_taken < 650);

   function automatic void add_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                    bit settle);
      stack_cmd_type it;
      it.cmd    = cmd;
      it.value  = value;
      it.settle = settle;
      cmd_backlog.push_back(it);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) != 0)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom();
   endfunction

   function automatic void apply_stack_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      stack_result_type r;
      int               i;
      r.read_value      = '0;
      r.found           = 1'b0;
      r.offset_from_top = '0;
      r.status          = STATUS_OK;
      case (cmd)
         CMD_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = value;
               shadow_fill++;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = shadow_words[shadow_fill - 1];
               if (cmd == CMD_POP)
                  shadow_fill--;
            end
         end
         CMD_SEARCH: begin
            for (i = shadow_fill - 1; i >= 0 && !r.found; i--) begin
               if (shadow_words[i] == value) begin
                  r.found           = 1'b1;
                  r.offset_from_top = OFFSET_W'(shadow_fill - 1 - i);
               end
            end
         end
         CMD_CLEAR: shadow_fill = 0;
         default: ;
      endcase
      r.fill_count = FILL_W'(shadow_fill);
      r.is_empty   = (shadow_fill == 0);
      stack_results_q.push_back(r);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (cmd_backlog.size() != 0
             && !(cmd_backlog[0].settle && stack_results_q.size() != 0)
             && !(!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
            next_cmd = cmd_backlog.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.cmd        <= next_cmd.cmd;
            req_chan.item_value <= next_cmd.value;
            req_busy = 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         apply_stack_cmd(req_chan.cmd, req_chan.item_value);
         req_busy = 1'b0;
         items_taken++;
      end
   end

   // result monitor
   always @(negedge clock) begin
      if (!reset)
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (stack_results_q.size() == 0) begin
            $error("result item with no command outstanding");
            mismatches++;
         end else begin
            want = stack_results_q.pop_front();
            check_field("read_value", want.read_value, rsp_chan.read_value);
            check_field("found", 32'(want.found), 32'(rsp_chan.found));
            check_field("offset_from_top", 32'(want.offset_from_top),
                        32'(rsp_chan.offset_from_top));
            check_field("fill_count", 32'(want.fill_count), 32'(rsp_chan.fill_count));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_chan.is_empty));
            check_field("status", 32'(want.status), 32'(rsp_chan.status));
         end
      end
   end

   initial begin
      int                 n;
      int                 k;
      int                 r;
      logic [VALUE_W-1:0] marker;

      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_PUSH;
      req_chan.item_value = '0;
      rsp_chan.ready      = 1'b0;

      foreach (value_pool[i])
         value_pool[i] = $urandom();

      // directed
      add_item(CMD_POP, 32'h0, 1'b0);
      add_item(CMD_PEEK, 32'hFFFF_FFFF, 1'b0);
      add_item(CMD_SEARCH, 32'h0, 1'b0);
      add_item(CMD_PUSH, 32'h0, 1'b0);
      add_item(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
      add_item(CMD_PEEK, 32'h0, 1'b0);
      add_item(CMD_SEARCH, 32'h0, 1'b0);
      add_item(CMD_SEARCH, 32'hFFFF_FFFF, 1'b0);
      add_item(CMD_SEARCH, 32'h5A5A_5A5A, 1'b0);
      add_item(CMD_PUSH, 32'hA5A5_A5A5, 1'b0);
      add_item(CMD_POP, 32'h0, 1'b0);
      add_item(CMD_POP, 32'h0, 1'b0);
      add_item(CMD_POP, 32'h0, 1'b0);
      add_item(CMD_POP, 32'h0, 1'b1);
      add_item(CMD_PUSH, 32'h1, 1'b0);
      add_item(CMD_CLEAR, 32'hFFFF_FFFF, 1'b0);
      add_item(CMD_PEEK, 32'h0, 1'b0);
      add_item(CMD_UNDEF_FIRST, $urandom(), 1'b0);
      add_item(CMD_UNDEF_FIRST + 3'd1, $urandom(), 1'b0);
      add_item(CMD_UNDEF_LAST, $urandom(), 1'b0);
      add_item(CMD_PUSH, 32'h8000_0000, 1'b0);
      add_item(CMD_UNDEF_LAST, 32'hFFFF_FFFF, 1'b0);
      add_item(CMD_CLEAR, 32'h0, 1'b0);
      // stale words stay in memory but must not match
      add_item(CMD_SEARCH, 32'h8000_0000, 1'b0);

      while (cmd_backlog.size() < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(8, 30);
               repeat (n) begin
                  r = $urandom_range(0, 99);
                  if (r < 38)      add_item(CMD_PUSH, pick_value(), 1'b0);
                  else if (r < 56) add_item(CMD_POP, $urandom(), 1'b0);
                  else if (r < 66) add_item(CMD_PEEK, $urandom(), 1'b0);
                  else if (r < 90) add_item(CMD_SEARCH, pick_value(), 1'b0);
                  else if (r < 94) add_item(CMD_CLEAR, $urandom(), 1'b0);
                  else if (r < 97)
                     add_item(CMD_W'($urandom_range(CMD_UNDEF_LAST, CMD_UNDEF_FIRST)),
                              $urandom(), 1'b0);
                  else             add_item(CMD_PUSH, $urandom(), 1'b0);
               end
            end
            4, 5, 6: begin
               add_item(CMD_CLEAR, $urandom(), $urandom_range(0, 2) == 0);
               k = ($urandom_range(0, 3) == 0) ? STACK_DEPTH + 2 : $urandom_range(1, STACK_DEPTH);
               repeat (k) add_item(CMD_PUSH, pick_value(), 1'b0);
               n = $urandom_range(3, 10);
               repeat (n) begin
                  if ($urandom_range(0, 3) == 0) add_item(CMD_PEEK, $urandom(), 1'b0);
                  else                           add_item(CMD_SEARCH, pick_value(), 1'b0);
               end
               n = $urandom_range(0, k);
               repeat (n) add_item(CMD_POP, $urandom(), 1'b0);
            end
            7: begin
               // match at the very bottom of a full stack
               marker = $urandom();
               add_item(CMD_CLEAR, $urandom(), 1'b1);
               add_item(CMD_PUSH, marker, 1'b0);
               repeat (STACK_DEPTH - 1) add_item(CMD_PUSH, pick_value(), 1'b0);
               add_item(CMD_SEARCH, marker, 1'b0);
               add_item(CMD_PUSH, pick_value(), 1'b0);
               add_item(CMD_SEARCH, marker, 1'b0);
               add_item(CMD_PEEK, $urandom(), 1'b0);
               n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
               repeat (n) add_item(CMD_POP, $urandom(), 1'b0);
               add_item(CMD_SEARCH, marker, 1'b0);
            end
            8: begin
               n = $urandom_range(3, 12);
               repeat (n) add_item(CMD_W'($urandom_range(0, CMD_UNDEF_LAST)), $urandom(), 1'b0);
            end
            default: begin
               foreach (value_pool[i])
                  value_pool[i] = $urandom();
            end
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_busy || stack_results_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
src/sls_pkg.sv
src/sls_req_if.sv
src/sls_rsp_if.sv
src/sls_ram.sv
src/sls_ctrl.sv
src/sls_datapath.sv
src/searchable_lifo_stack.sv
sim/searchable_lifo_stack_tb.sv
